// ===== src/dpts_pkg.sv =====
package dpts_pkg;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_SET    = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_SELECT = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_UNUSED   = 2'd0,
    ST_SLEEPING = 2'd1,
    ST_RUNNABLE = 2'd2,
    ST_RUNNING  = 2'd3
  } slot_st_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_TICK_RD,
    S_TICK_WR,
    S_SEL_RD,
    S_SEL_PREP,
    S_SEL_DIV,
    S_SEL_CMP,
    S_FIN_RD,
    S_FIN_WR,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  slot;
    logic [1:0]  new_state;
    logic [6:0]  static_pri;
    logic [31:0] create_time;
    logic        pri_override;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [5:0] chosen_slot;
    logic [6:0] chosen_dp;
  } out_t;

  localparam logic [3:0] NICE_DEF = 4'd5;
  localparam logic [7:0] DP_BIAS  = 8'd5;
  localparam logic [7:0] DP_MAX   = 8'd100;

endpackage

// ===== src/dynamic_priority_task_select.sv =====
// Allocate and set-state give their result beat in the cycle after acceptance.
// Tick walks every slot, reading each through the registered table read and then writing it back.
// Select reads each slot in turn; a runnable slot is compared in S_SEL_CMP, and before that goes
// through the shared 4-step restoring divider when the divider runs for it.
// Throughput: one item at a time; the input stalls during a walk and while a result beat waits.
// Reset: a clearing pass marks every slot unused, with the input stalled.
module dynamic_priority_task_select
  import dpts_pkg::*;
#(
  parameter int NUM_SLOTS  = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CB = COUNT_BITS;
  localparam int RW = COUNT_BITS + 4;
  localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);

  logic [6:0]    mem_pri [NUM_SLOTS];
  logic [31:0]   mem_ct  [NUM_SLOTS];
  logic          mem_ovr [NUM_SLOTS];
  logic [CB-1:0] mem_slp [NUM_SLOTS];
  logic [CB-1:0] mem_run [NUM_SLOTS];
  logic [CB-1:0] mem_tc  [NUM_SLOTS];
  slot_st_t      mem_st  [NUM_SLOTS];

  fsm_t state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] best_r, best_nxt;
  logic          have_r, have_nxt;
  logic [6:0]    best_dp_r, best_dp_nxt;
  logic [CB-1:0] best_tc_r, best_tc_nxt;
  logic [31:0]   best_ct_r, best_ct_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [CB:0]   den_r, den_nxt;
  logic [3:0]    q_r, q_nxt;
  logic [1:0]    step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_data_r, out_data_nxt;

  logic [6:0]    rd_pri_r;
  logic [31:0]   rd_ct_r;
  logic          rd_ovr_r;
  logic [CB-1:0] rd_slp_r, rd_run_r, rd_tc_r;
  slot_st_t      rd_st_r;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [6:0]    wr_pri;
  logic [31:0]   wr_ct;
  logic          wr_ovr;
  logic [CB-1:0] wr_slp, wr_run, wr_tc;
  logic          st_wr_en;
  logic [IW-1:0] st_wr_addr;
  slot_st_t      st_wr_val;

  logic          out_free, accept, in_range;
  logic [8:0]    slot_w;
  logic [IW-1:0] slot_a;
  slot_st_t      cur_st;
  logic [CB:0]   total;
  logic [RW-1:0] trial;
  logic [7:0]    dp_t, dp_d;
  logic [6:0]    dp;
  logic          better;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign slot_w   = 9'(in_data.slot);
  assign in_range = slot_w < 9'(NUM_SLOTS);
  assign slot_a   = IW'(slot_w);
  assign cur_st   = rd_st_r;
  assign total    = (CB+1)'(rd_slp_r) + (CB+1)'(rd_run_r);
  assign trial    = RW'(den_r) << step_r;
  assign dp_t     = 8'(rd_pri_r) + DP_BIAS;
  assign dp_d     = dp_t - 8'(q_r);
  assign dp       = (dp_t < 8'(q_r)) ? 7'd0 : ((dp_d > DP_MAX) ? 7'(DP_MAX) : dp_d[6:0]);
  assign better   = !have_r || (dp < best_dp_r) ||
                    ((dp == best_dp_r) &&
                     (((best_tc_r == rd_tc_r) && (best_ct_r < rd_ct_r)) ||
                      (best_tc_r > rd_tc_r)));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && act_t'(in_data.action) == ACT_TICK) state_nxt = S_TICK_RD;
        else if (accept && act_t'(in_data.action) == ACT_SELECT) state_nxt = S_SEL_RD;
      end
      S_CLEAR: if (idx_r == LAST) state_nxt = S_IDLE;
      S_TICK_RD: state_nxt = S_TICK_WR;
      S_TICK_WR: state_nxt = (idx_r == LAST) ? S_DONE : S_TICK_RD;
      S_SEL_RD: state_nxt = S_SEL_PREP;
      S_SEL_PREP: begin
        if (cur_st != ST_RUNNABLE) begin
          if (idx_r == LAST) state_nxt = have_r ? S_FIN_RD : S_DONE;
          else state_nxt = S_SEL_RD;
        end else if (rd_ovr_r || rd_tc_r == '0 || total == '0) state_nxt = S_SEL_CMP;
        else state_nxt = S_SEL_DIV;
      end
      S_SEL_DIV: if (step_r == 2'd0) state_nxt = S_SEL_CMP;
      S_SEL_CMP: begin
        if (idx_r != LAST) state_nxt = S_SEL_RD;
        else state_nxt = S_FIN_RD;
      end
      S_FIN_RD: state_nxt = S_FIN_WR;
      S_FIN_WR: state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    have_nxt      = have_r;
    best_dp_nxt   = best_dp_r;
    best_tc_nxt   = best_tc_r;
    best_ct_nxt   = best_ct_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_pri        = rd_pri_r;
    wr_ct         = rd_ct_r;
    wr_ovr        = rd_ovr_r;
    wr_slp        = rd_slp_r;
    wr_run        = rd_run_r;
    wr_tc         = rd_tc_r;
    st_wr_en      = 1'b0;
    st_wr_addr    = slot_a;
    st_wr_val     = slot_st_t'(in_data.new_state);
    case (state_r)
      S_IDLE: begin
        idx_nxt  = '0;
        have_nxt = 1'b0;
        if (accept) begin
          out_data_nxt = '0;
          case (act_t'(in_data.action))
            ACT_ALLOC: begin
              out_valid_nxt = 1'b1;
              wr_en   = in_range;
              wr_addr = slot_a;
              wr_pri  = in_data.static_pri;
              wr_ct   = in_data.create_time;
              wr_ovr  = in_data.pri_override;
              wr_slp  = '0;
              wr_run  = '0;
              wr_tc   = '0;
            end
            ACT_SET: begin
              out_valid_nxt = 1'b1;
              st_wr_en = in_range;
            end
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        st_wr_en   = 1'b1;
        st_wr_addr = idx_r;
        st_wr_val  = ST_UNUSED;
        idx_nxt    = idx_r + 1'b1;
      end
      S_TICK_RD: rd_en = 1'b1;
      S_TICK_WR: begin
        if (cur_st == ST_RUNNING) begin
          wr_en  = 1'b1;
          wr_run = (rd_run_r == '1) ? rd_run_r : rd_run_r + 1'b1;
        end else if (cur_st == ST_SLEEPING) begin
          wr_en  = 1'b1;
          wr_slp = (rd_slp_r == '1) ? rd_slp_r : rd_slp_r + 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
      end
      S_SEL_RD: rd_en = 1'b1;
      S_SEL_PREP: begin
        if (cur_st != ST_RUNNABLE) idx_nxt = idx_r + 1'b1;
        rem_nxt  = (RW'(rd_slp_r) << 3) + (RW'(rd_slp_r) << 1);
        den_nxt  = total;
        step_nxt = 2'd3;
        q_nxt    = (rd_ovr_r || rd_tc_r == '0 || total == '0) ? NICE_DEF : 4'd0;
      end
      S_SEL_DIV: begin
        if (rem_r >= trial) begin
          rem_nxt        = rem_r - trial;
          q_nxt[step_r]  = 1'b1;
        end
        step_nxt = step_r - 1'b1;
      end
      S_SEL_CMP: begin
        if (better) begin
          have_nxt    = 1'b1;
          best_nxt    = idx_r;
          best_dp_nxt = dp;
          best_tc_nxt = rd_tc_r;
          best_ct_nxt = rd_ct_r;
        end
        idx_nxt = idx_r + 1'b1;
      end
      S_FIN_RD: begin
        rd_en   = 1'b1;
        rd_addr = best_r;
      end
      S_FIN_WR: begin
        wr_en      = 1'b1;
        wr_addr    = best_r;
        wr_ovr     = 1'b0;
        wr_slp     = '0;
        wr_run     = '0;
        wr_tc      = (rd_tc_r == '1) ? rd_tc_r : rd_tc_r + 1'b1;
        st_wr_en   = 1'b1;
        st_wr_addr = best_r;
        st_wr_val  = ST_RUNNING;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.found       = have_r;
          out_data_nxt.chosen_slot = have_r ? 6'(best_r) : 6'd0;
          out_data_nxt.chosen_dp   = have_r ? best_dp_r : 7'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_pri[wr_addr] <= wr_pri;
      mem_ct[wr_addr]  <= wr_ct;
      mem_ovr[wr_addr] <= wr_ovr;
      mem_slp[wr_addr] <= wr_slp;
      mem_run[wr_addr] <= wr_run;
      mem_tc[wr_addr]  <= wr_tc;
    end
    if (st_wr_en) mem_st[st_wr_addr] <= st_wr_val;
    if (rd_en) begin
      rd_pri_r <= mem_pri[rd_addr];
      rd_ct_r  <= mem_ct[rd_addr];
      rd_ovr_r <= mem_ovr[rd_addr];
      rd_slp_r <= mem_slp[rd_addr];
      rd_run_r <= mem_run[rd_addr];
      rd_tc_r  <= mem_tc[rd_addr];
      rd_st_r  <= mem_st[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      have_r      <= have_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r     <= best_nxt;
    best_dp_r  <= best_dp_nxt;
    best_tc_r  <= best_tc_nxt;
    best_ct_r  <= best_ct_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    q_r        <= q_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("input taken mid-walk");

  a_dp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found) |-> (out_data.chosen_dp <= 7'(DP_MAX)))
    else $error("dp out of range");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |->
      (out_data.chosen_slot == 6'd0 && out_data.chosen_dp == 7'd0))
    else $error("empty result not zero");

  a_winner_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN_WR) |->
      (st_wr_en && st_wr_addr == best_r && st_wr_val == ST_RUNNING))
    else $error("winner not running");

endmodule
